// File: src/mdeb_pkg.sv
package mdeb_pkg;

    localparam int N_MAX      = 16;
    localparam int CNT_W      = 5;
    localparam int FALL_W     = 8;
    localparam int DLY_W      = 4;
    localparam int SCAN_W     = 6;
    localparam int CFG_DATA_W = 64;

    localparam int NUM_INPUTS_DEF = 16;
    localparam int PIN_LIMIT_DEF  = 20;
    localparam int IR_LIMIT_DEF   = 5;
    localparam int FALL_SCALE_DEF = 10;

    typedef enum logic [1:0] {
        OP_PIN  = 2'd0,
        OP_IR   = 2'd1,
        OP_FALL = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } t_event;

    typedef enum logic [0:0] {
        CFG_IR_MASK     = 1'b0,
        CFG_FALL_DELAYS = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic       en;
        logic [1:0] op;
    } t_tick;

    typedef struct packed {
        logic deb;
        logic lvl;
    } t_lane_stat;

    typedef struct packed {
        logic       scan_done;
        logic       down;
        logic [1:0] ev;
    } t_btn_stat;

endpackage

// File: src/multi_input_debouncer_with_fall_delay_top.sv
// Debouncer for up to sixteen inputs with per-input fall delay and a push button.
// Input channel (i_valid, o_stall): one transaction is one tick, selected by
// i_operation: a pin tick, an IR tick or a fall tick. Every lane updates its
// counters in the cycle the transaction is accepted.
// Output channel (o_valid, i_stall): exactly one result transaction per input
// transaction, in order, showing the state after that tick.
// The merged result of an accepted tick is registered and then shown with o_valid.
// Throughput is one tick per cycle while the output is not stalled; all lanes work in parallel.
// A two-entry output buffer lets one more tick be accepted while a result is
// stalled; o_stall rises only when both entries are full.
// The configuration channel (i_cfg_valid, o_cfg_ready) writes the IR mask
// (index 0) or the packed fall delays (index 1); it is always ready. The user
// must write it only while the block is idle; the block does not enforce this.
// Synchronous reset clears all counters, flags, configuration and the output
// buffer; the block accepts ticks as soon as reset is released.
module multi_input_debouncer_with_fall_delay_top #(
    parameter int NUM_INPUTS = mdeb_pkg::NUM_INPUTS_DEF,
    parameter int PIN_LIMIT  = mdeb_pkg::PIN_LIMIT_DEF,
    parameter int IR_LIMIT   = mdeb_pkg::IR_LIMIT_DEF,
    parameter int FALL_SCALE = mdeb_pkg::FALL_SCALE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_operation,
    input  logic [mdeb_pkg::N_MAX-1:0]          i_sample_bits,
    input  logic                                i_button_level,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [mdeb_pkg::N_MAX-1:0]          o_debounced_bits,
    output logic [mdeb_pkg::N_MAX-1:0]          o_logic_bits,
    output logic                                o_scan_done,
    output logic                                o_button_down,
    output logic [1:0]                          o_button_event,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [0:0]                          i_cfg_index,
    input  logic [mdeb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int N = mdeb_pkg::N_MAX;

    typedef struct packed {
        logic [N-1:0] deb;
        logic [N-1:0] lvl;
        logic         scan_done;
        logic         down;
        logic [1:0]   ev;
    } t_result;

    logic [N-1:0]                    r_ir_mask;
    logic [mdeb_pkg::CFG_DATA_W-1:0] r_fall_delays;

    mdeb_pkg::t_tick                 w_tick;
    mdeb_pkg::t_btn_stat             w_btn;
    logic [N-1:0]                    w_deb;
    logic [N-1:0]                    w_lvl;
    t_result                         w_res;

    logic                            w_accept;
    logic                            w_take;
    logic                            r_out_valid, n_out_valid;
    logic                            r_skid_valid, n_skid_valid;
    t_result                         r_out, r_skid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ir_mask     <= '0;
            r_fall_delays <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                mdeb_pkg::CFG_IR_MASK:     r_ir_mask     <= i_cfg_data[N-1:0];
                mdeb_pkg::CFG_FALL_DELAYS: r_fall_delays <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_stall   = r_skid_valid;
    assign w_accept  = i_valid && !o_stall;
    assign w_tick.en = w_accept;
    assign w_tick.op = i_operation;

    for (genvar g = 0; g < N; g++) begin : g_lane
        if (g < NUM_INPUTS) begin : g_used
            mdeb_pkg::t_lane_stat w_stat;

            mdeb_lane #(
                .PinLimit  (PIN_LIMIT),
                .IrLimit   (IR_LIMIT),
                .FallScale (FALL_SCALE)
            ) u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_tick   (w_tick),
                .i_sample (i_sample_bits[g]),
                .i_ir_sel (r_ir_mask[g]),
                .i_delay  (r_fall_delays[g*mdeb_pkg::DLY_W +: mdeb_pkg::DLY_W]),
                .o_stat   (w_stat)
            );

            assign w_deb[g] = w_stat.deb;
            assign w_lvl[g] = w_stat.lvl;
        end else begin : g_unused
            assign w_deb[g] = 1'b0;
            assign w_lvl[g] = 1'b0;
        end
    end

    mdeb_btn #(
        .PinLimit (PIN_LIMIT)
    ) u_btn (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick         (w_tick),
        .i_button_level (i_button_level),
        .o_stat         (w_btn)
    );

    assign w_res.deb       = w_deb;
    assign w_res.lvl       = w_lvl;
    assign w_res.scan_done = w_btn.scan_done;
    assign w_res.down      = w_btn.down;
    assign w_res.ev        = w_btn.ev;

    assign w_take = r_out_valid && !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (w_take) begin
            if (r_skid_valid) begin
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = w_accept;
            end
        end else if (w_accept) begin
            if (r_out_valid) begin
                n_skid_valid = 1'b1;
            end else begin
                n_out_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && r_skid_valid) begin
            r_out <= r_skid;
        end else if (w_accept && (w_take || !r_out_valid)) begin
            r_out <= w_res;
        end
        if (w_accept && r_out_valid && !w_take) begin
            r_skid <= w_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_debounced_bits = r_out.deb;
    assign o_logic_bits     = r_out.lvl;
    assign o_scan_done      = r_out.scan_done;
    assign o_button_down    = r_out.down;
    assign o_button_event   = r_out.ev;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the output entry is empty");

    a_logic_covers_deb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_logic_bits & o_debounced_bits) == o_debounced_bits))
        else $error("debounced bit set without its logic bit");

    a_press_sets_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_button_event == mdeb_pkg::EV_PRESS) |-> o_button_down)
        else $error("press event without the button down flag");

    a_stalled_accept_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && o_valid && i_stall) |=> r_skid_valid)
        else $error("transaction accepted under stall was not buffered");
`endif

endmodule

// File: src/mdeb_lane.sv
module mdeb_lane #(
    parameter int PinLimit  = mdeb_pkg::PIN_LIMIT_DEF,
    parameter int IrLimit   = mdeb_pkg::IR_LIMIT_DEF,
    parameter int FallScale = mdeb_pkg::FALL_SCALE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mdeb_pkg::t_tick                i_tick,
    input  logic                           i_sample,
    input  logic                           i_ir_sel,
    input  logic [mdeb_pkg::DLY_W-1:0]     i_delay,
    output mdeb_pkg::t_lane_stat           o_stat
);

    localparam logic [mdeb_pkg::CNT_W-1:0]  LimPin = mdeb_pkg::CNT_W'(PinLimit);
    localparam logic [mdeb_pkg::CNT_W-1:0]  LimIr  = mdeb_pkg::CNT_W'(IrLimit);
    localparam logic [mdeb_pkg::FALL_W-1:0] Scale  = mdeb_pkg::FALL_W'(FallScale);

    logic [mdeb_pkg::CNT_W-1:0]  r_cnt,  n_cnt;
    logic [mdeb_pkg::FALL_W-1:0] r_fall, n_fall;
    logic                        r_deb,  n_deb;
    logic                        r_lvl,  n_lvl;

    logic                        w_move;
    logic                        w_level;
    logic [mdeb_pkg::CNT_W-1:0]  w_lim;

    always_comb begin
        w_move  = 1'b0;
        w_level = 1'b0;
        w_lim   = LimPin;
        case (i_tick.op)
            mdeb_pkg::OP_PIN: begin
                w_move  = !i_ir_sel;
                w_level = !i_sample;
                w_lim   = LimPin;
            end
            mdeb_pkg::OP_IR: begin
                w_move  = i_ir_sel;
                w_level = i_sample;
                w_lim   = LimIr;
            end
            default: begin
                w_move = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_cnt  = r_cnt;
        n_fall = r_fall;
        n_deb  = r_deb;
        n_lvl  = r_lvl;
        if (w_move) begin
            if (w_level) begin
                if (r_cnt < w_lim) begin
                    n_cnt = r_cnt + 1'b1;
                    if (n_cnt == w_lim) begin
                        n_deb  = 1'b1;
                        n_lvl  = 1'b1;
                        n_fall = '0;
                    end
                end
            end else if (r_cnt != '0) begin
                n_cnt = r_cnt - 1'b1;
                if (n_cnt == '0) begin
                    n_deb  = 1'b0;
                    n_fall = mdeb_pkg::FALL_W'(i_delay) * Scale;
                    if (n_fall == '0) begin
                        n_lvl = 1'b0;
                    end
                end
            end
        end else if (i_tick.op == mdeb_pkg::OP_FALL && r_fall != '0) begin
            n_fall = r_fall - 1'b1;
            if (n_fall == '0) begin
                n_lvl = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_fall <= '0;
            r_deb  <= 1'b0;
            r_lvl  <= 1'b0;
        end else if (i_tick.en) begin
            r_cnt  <= n_cnt;
            r_fall <= n_fall;
            r_deb  <= n_deb;
            r_lvl  <= n_lvl;
        end
    end

    assign o_stat.deb = n_deb;
    assign o_stat.lvl = n_lvl;

endmodule

// File: src/mdeb_btn.sv
module mdeb_btn #(
    parameter int PinLimit = mdeb_pkg::PIN_LIMIT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mdeb_pkg::t_tick     i_tick,
    input  logic                i_button_level,
    output mdeb_pkg::t_btn_stat o_stat
);

    localparam logic [mdeb_pkg::CNT_W-1:0]  LimBtn  = mdeb_pkg::CNT_W'(PinLimit);
    localparam logic [mdeb_pkg::SCAN_W-1:0] LimScan = mdeb_pkg::SCAN_W'(2 * PinLimit);

    logic [mdeb_pkg::SCAN_W-1:0] r_scan_cnt, n_scan_cnt;
    logic                        r_scanned,  n_scanned;
    logic [mdeb_pkg::CNT_W-1:0]  r_btn_cnt,  n_btn_cnt;
    logic                        r_btn_flag, n_btn_flag;
    logic [1:0]                  n_ev;

    always_comb begin
        n_scan_cnt = r_scan_cnt;
        n_scanned  = r_scanned;
        n_btn_cnt  = r_btn_cnt;
        n_btn_flag = r_btn_flag;
        n_ev       = mdeb_pkg::EV_NONE;
        if (i_tick.op == mdeb_pkg::OP_PIN) begin
            if (r_scan_cnt < LimScan) begin
                n_scan_cnt = r_scan_cnt + 1'b1;
                if (n_scan_cnt == LimScan) begin
                    n_scanned = 1'b1;
                end
            end
            if (i_button_level) begin
                if (r_btn_cnt != '0) begin
                    n_btn_cnt = r_btn_cnt - 1'b1;
                    if (n_btn_cnt == '0 && r_btn_flag) begin
                        n_btn_flag = 1'b0;
                        n_ev       = mdeb_pkg::EV_RELEASE;
                    end
                end
            end else if (r_btn_cnt < LimBtn) begin
                n_btn_cnt = r_btn_cnt + 1'b1;
                if (n_btn_cnt == LimBtn && !r_btn_flag) begin
                    n_btn_flag = 1'b1;
                    n_ev       = mdeb_pkg::EV_PRESS;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_cnt <= '0;
            r_scanned  <= 1'b0;
            r_btn_cnt  <= '0;
            r_btn_flag <= 1'b0;
        end else if (i_tick.en) begin
            r_scan_cnt <= n_scan_cnt;
            r_scanned  <= n_scanned;
            r_btn_cnt  <= n_btn_cnt;
            r_btn_flag <= n_btn_flag;
        end
    end

    assign o_stat.scan_done = n_scanned;
    assign o_stat.down      = n_btn_flag;
    assign o_stat.ev        = n_ev;

endmodule
